// ===== sv/neo_hookean_energy_and_stress_top_macros.svh =====
// Assertion macros shared by the neo-Hookean pipeline modules.
// Expects clk and rst_n in the scope of the including module.
`ifndef NEO_HOOKEAN_ENERGY_AND_STRESS_TOP_MACROS_SVH
`define NEO_HOOKEAN_ENERGY_AND_STRESS_TOP_MACROS_SVH

// same-cycle implication
`define NHES_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NHES_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nhes_pkg.sv =====
// Shared types, constants and saturation helpers for the neo-Hookean pipeline.
// No dependencies.
package nhes_pkg;

  localparam int WORD_W    = 32;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CQ_W      = 48;
  localparam int ICM_W     = 51;
  localparam int MUL_A_W   = 64;
  localparam int MUL_B_W   = 52;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [8:0]              mat_t;
  typedef logic signed [CQ_W-1:0]   cq_t;
  typedef cq_t [8:0]                cqm_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MU     = 2'd0,
    REG_LAMBDA = 2'd1,
    REG_ALPHA  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] mu;
    logic [CFG_W-1:0] lam;
    logic [CFG_W-1:0] alpha;
  } cfg_t;

  // handoff from the geometry half to the response half
  typedef struct packed {
    mat_t                    g;
    cqm_t                    cq;
    logic signed [ICM_W-1:0] icm;
    cq_t                     d;
  } geo_t;

  typedef struct packed {
    word_t energy;
    mat_t  p;
  } res_t;

  localparam logic [CFG_W-1:0] MU_RST    = 31'd65536;
  localparam logic [CFG_W-1:0] LAMBDA_RST = 31'd131072;
  localparam logic [CFG_W-1:0] ALPHA_RST = 31'd98304;

  localparam cq_t   D_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam cq_t   D_MIN = 48'sh8000_0000_0000;
  localparam word_t W_MAX = 32'sh7FFF_FFFF;
  localparam word_t W_MIN = 32'sh8000_0000;

  // Ic - 3.0 in Q32.32 plus the half LSB for the shift by 16
  localparam logic signed [66:0]        ICM_BIAS = 67'sd32768 - 67'sd12884901888;
  localparam logic signed [97:0]        J_RND    = 98'sd2147483648;
  localparam logic signed [MUL_P_W-1:0] S_RND    = 116'sd32768;
  localparam logic signed [MUL_P_W-1:0] E_RND    = 116'sd65536;

  function automatic int nx3(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

  function automatic cq_t sat_d48(input logic signed [65:0] x);
    cq_t r;
    if (x[65:47] == {19{x[65]}}) begin
      r = x[47:0];
    end else if (x[65]) begin
      r = D_MIN;
    end else begin
      r = D_MAX;
    end
    return r;
  endfunction

  function automatic word_t sat_w32(input logic signed [99:0] x);
    word_t r;
    if (x[99:31] == {69{x[99]}}) begin
      r = x[31:0];
    end else if (x[99]) begin
      r = W_MIN;
    end else begin
      r = W_MAX;
    end
    return r;
  endfunction

endpackage

// ===== sv/nhes_in_if.sv =====
// Input channel: one deformation gradient per transfer, valid/ready.
// Depends on nhes_pkg.
interface nhes_in_if;
  import nhes_pkg::*;
  logic  valid;
  logic  ready;
  word_t f00, f01, f02, f10, f11, f12, f20, f21, f22;
  modport source (output valid, f00, f01, f02, f10, f11, f12, f20, f21, f22,
                  input ready);
  modport sink   (input valid, f00, f01, f02, f10, f11, f12, f20, f21, f22,
                  output ready);
endinterface

// ===== sv/nhes_out_if.sv =====
// Result channel: energy and stress per transfer, valid/ready.
// Depends on nhes_pkg.
interface nhes_out_if;
  import nhes_pkg::*;
  logic  valid;
  logic  ready;
  word_t energy, p00, p01, p02, p10, p11, p12, p20, p21, p22;
  modport source (output valid, energy, p00, p01, p02, p10, p11, p12, p20, p21, p22,
                  input ready);
  modport sink   (input valid, energy, p00, p01, p02, p10, p11, p12, p20, p21, p22,
                  output ready);
endinterface

// ===== sv/nhes_mul.sv =====
// Two-stage signed 64 x 52 multiplier built from four 32-bit-class partials.
// Depends on nhes_pkg.
module nhes_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [nhes_pkg::MUL_A_W-1:0] a,
  input  logic signed [nhes_pkg::MUL_B_W-1:0] b,
  output logic signed [nhes_pkg::MUL_P_W-1:0] p
);
  import nhes_pkg::*;

  logic        [31:0]        a_lo, b_lo;
  logic signed [31:0]        a_hi;
  logic signed [19:0]        b_hi;
  logic        [63:0]        ll_r;
  logic signed [52:0]        lh_r;
  logic signed [64:0]        hl_r;
  logic signed [51:0]        hh_r;
  logic signed [65:0]        mid;
  logic signed [MUL_P_W-1:0] p_nxt, p_r;

  assign a_lo = a[31:0];
  assign a_hi = a[63:32];
  assign b_lo = b[31:0];
  assign b_hi = b[51:32];

  always_comb begin
    mid   = lh_r + hl_r;
    p_nxt = $signed({hh_r, 64'd0}) + $signed({{18{mid[65]}}, mid, 32'd0})
          + $signed({52'd0, ll_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a_lo * b_lo;
      lh_r <= $signed({1'b0, a_lo}) * b_hi;
      hl_r <= a_hi * $signed({1'b0, b_lo});
      hh_r <= a_hi * b_hi;
      p_r  <= p_nxt;
    end
  end

  assign p = p_r;
endmodule

// ===== sv/nhes_geom.sv =====
// Stages 1-6: cofactors, squared norm, determinant and J - alpha.
// Depends on nhes_pkg, nhes_mul and the assertion macro header.
`include "neo_hookean_energy_and_stress_top_macros.svh"
module nhes_geom (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  nhes_pkg::mat_t  in_g,
  input  nhes_pkg::cfg_t  cfg,
  output logic            geo_valid,
  output nhes_pkg::geo_t  geo
);
  import nhes_pkg::*;

  logic [5:0]              v_r;
  mat_t                    g_r [1:6];
  logic signed [63:0]      pa_nxt [9], pb_nxt [9], sq_full [9];
  logic signed [63:0]      pa_r [9], pb_r [9];
  logic        [62:0]      sq_r [9];
  logic signed [63:0]      cof_nxt [9], cof_r [9];
  logic        [63:0]      ic3_nxt [3], ic3_r [3];
  logic signed [64:0]      cq_t65 [9];
  cqm_t                    cq_nxt;
  cqm_t                    cq_r [3:6];
  logic        [65:0]      ic_nxt, ic_r;
  logic signed [66:0]      icm_t;
  logic signed [ICM_W-1:0] icm_r [4:6];
  logic signed [MUL_P_W-1:0] jp [3];
  logic signed [97:0]      jsum_nxt, jsum_r;
  cq_t                     d_nxt, d_r;

  // cofactor product pairs and squares, straight from the port
  always_comb begin
    int i1, i2, j1, j2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        i1 = nx3(i);
        i2 = nx3(i1);
        j1 = nx3(j);
        j2 = nx3(j1);
        pa_nxt[i*3+j]  = $signed(in_g[i1*3+j1]) * $signed(in_g[i2*3+j2]);
        pb_nxt[i*3+j]  = $signed(in_g[i1*3+j2]) * $signed(in_g[i2*3+j1]);
        sq_full[i*3+j] = $signed(in_g[i*3+j]) * $signed(in_g[i*3+j]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      cof_nxt[k] = pa_r[k] - pb_r[k];
      cq_t65[k]  = $signed({cof_r[k][63], cof_r[k]}) + 65'sd32768;
      cq_nxt[k]  = cq_t65[k][63:16];
    end
    for (int i = 0; i < 3; i++) begin
      ic3_nxt[i] = {1'b0, sq_r[i*3]} + {1'b0, sq_r[i*3+1]} + {1'b0, sq_r[i*3+2]};
    end
    ic_nxt   = {2'b0, ic3_r[0]} + {2'b0, ic3_r[1]} + {2'b0, ic3_r[2]};
    icm_t    = $signed({1'b0, ic_r}) + ICM_BIAS;
    // det in Q48.48 minus alpha, with the half LSB for the shift by 32
    jsum_nxt = jp[0][97:0] + jp[1][97:0] + jp[2][97:0]
             - {35'd0, cfg.alpha, 32'd0} + J_RND;
    d_nxt    = sat_d48(jsum_r[97:32]);
  end

  // determinant row 0 expansion, two stages each
  for (genvar j = 0; j < 3; j++) begin : g_det
    nhes_mul u_mul (
      .clk (clk),
      .en  (en),
      .a   (cof_r[j]),
      .b   ({{20{g_r[2][j][31]}}, g_r[2][j]}),
      .p   (jp[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_r[1] <= in_g;
      for (int s = 2; s <= 6; s++) begin
        g_r[s] <= g_r[s-1];
      end
      pa_r  <= pa_nxt;
      pb_r  <= pb_nxt;
      for (int k = 0; k < 9; k++) begin
        sq_r[k] <= sq_full[k][62:0];
      end
      cof_r <= cof_nxt;
      ic3_r <= ic3_nxt;
      cq_r[3] <= cq_nxt;
      for (int s = 4; s <= 6; s++) begin
        cq_r[s] <= cq_r[s-1];
      end
      ic_r     <= ic_nxt;
      icm_r[4] <= icm_t[66:16];
      icm_r[5] <= icm_r[4];
      icm_r[6] <= icm_r[5];
      jsum_r   <= jsum_nxt;
      d_r      <= d_nxt;
    end
  end

  assign geo_valid = v_r[5];
  assign geo.g     = g_r[6];
  assign geo.cq    = cq_r[6];
  assign geo.icm   = icm_r[6];
  assign geo.d     = d_r;

  `NHES_ASSERT_NEXT(a_geo_hold, rst_n && !en, $stable(v_r), "geometry valids moved in a stall")
  `NHES_ASSERT_NEXT(a_geo_enter, en && in_valid, v_r[0], "transfer lost at stage one")
endmodule

// ===== sv/nhes_resp.sv =====
// Stages 7-13: lambda*d, energy and stress sums, rounding and saturation.
// Depends on nhes_pkg, nhes_mul and the assertion macro header.
`include "neo_hookean_energy_and_stress_top_macros.svh"
module nhes_resp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           geo_valid,
  input  nhes_pkg::geo_t geo,
  input  nhes_pkg::cfg_t cfg,
  output logic           res_valid,
  output nhes_pkg::res_t res
);
  import nhes_pkg::*;

  logic [6:0]                v_r;
  mat_t                      g_r [7:8];
  cqm_t                      cq_r [7:9];
  cq_t                       d_r [7:9];
  logic signed [MUL_P_W-1:0] lamd, mui_p, ldd;
  logic signed [MUL_P_W-1:0] ldcq [9];
  logic signed [79:0]        ld_t;
  logic signed [63:0]        ld_r;
  logic signed [82:0]        mui_r [9:11];
  logic signed [62:0]        mug_nxt [9];
  logic signed [62:0]        mug_r [9:11][9];
  logic signed [MUL_P_W-1:0] esum_nxt, esum_r;
  logic signed [MUL_P_W-1:0] ssum_nxt [9], ssum_r [9];
  res_t                      res_nxt, res_r;

  nhes_mul u_lamd (
    .clk (clk),
    .en  (en),
    .a   ({33'd0, cfg.lam}),
    .b   ({{4{geo.d[47]}}, geo.d}),
    .p   (lamd)
  );

  nhes_mul u_muicm (
    .clk (clk),
    .en  (en),
    .a   ({33'd0, cfg.mu}),
    .b   ({geo.icm[50], geo.icm}),
    .p   (mui_p)
  );

  nhes_mul u_ldd (
    .clk (clk),
    .en  (en),
    .a   (ld_r),
    .b   ({{4{d_r[9][47]}}, d_r[9]}),
    .p   (ldd)
  );

  for (genvar k = 0; k < 9; k++) begin : g_ldcq
    nhes_mul u_mul (
      .clk (clk),
      .en  (en),
      .a   (ld_r),
      .b   ({{4{cq_r[9][k][47]}}, cq_r[9][k]}),
      .p   (ldcq[k])
    );
  end

  always_comb begin
    ld_t = lamd[79:0] + 80'sd32768;
    for (int k = 0; k < 9; k++) begin
      mug_nxt[k]  = $signed({1'b0, cfg.mu}) * $signed(g_r[8][k]);
      ssum_nxt[k] = $signed({{53{mug_r[11][k][62]}}, mug_r[11][k]}) + ldcq[k] + S_RND;
      res_nxt.p[k] = sat_w32(ssum_r[k][115:16]);
    end
    // energy is halved inside the rounding shift
    esum_nxt       = $signed({{33{mui_r[11][82]}}, mui_r[11]}) + ldd + E_RND;
    res_nxt.energy = sat_w32({esum_r[115], esum_r[115:17]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], geo_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_r[7]  <= geo.g;
      g_r[8]  <= g_r[7];
      cq_r[7] <= geo.cq;
      cq_r[8] <= cq_r[7];
      cq_r[9] <= cq_r[8];
      d_r[7]  <= geo.d;
      d_r[8]  <= d_r[7];
      d_r[9]  <= d_r[8];
      ld_r    <= ld_t[79:16];
      mui_r[9]  <= mui_p[82:0];
      mui_r[10] <= mui_r[9];
      mui_r[11] <= mui_r[10];
      mug_r[9]  <= mug_nxt;
      mug_r[10] <= mug_r[9];
      mug_r[11] <= mug_r[10];
      esum_r <= esum_nxt;
      ssum_r <= ssum_nxt;
      res_r  <= res_nxt;
    end
  end

  assign res_valid = v_r[6];
  assign res       = res_r;

  `NHES_ASSERT_NEXT(a_rsp_hold, rst_n && !en, $stable(v_r), "response valids moved in a stall")
  `NHES_ASSERT_NEXT(a_rsp_enter, en && geo_valid, v_r[0], "item lost between the halves")
endmodule

// ===== sv/neo_hookean_energy_and_stress_top.sv =====
// Top level: stable neo-Hookean energy and PK1 stress pipeline.
// Depends on nhes_pkg, nhes_in_if, nhes_out_if, nhes_geom and nhes_resp.
//
// channel   dir  payload                   handshake
// in_ch     in   f00..f22, 9 x 32 signed   valid/ready
// out_ch    out  energy, p00..p22, 10 x 32 valid/ready
// cfg_*     in   2-bit index, 31-bit data  write enable, always taken
//
// In_ch items pass the geometry then response stages to out_ch, one per cycle
// each way unless stalled. Each 64 x 52 product is split over two stages.
// Reset clears the stage valids and loads mu 1.0, lambda 2.0, alpha 1.5.
// A result held by out_ch.ready low freezes all stages; in_ch.ready drops with it.
module neo_hookean_energy_and_stress_top (
  input  logic                               clk,
  input  logic                               rst_n,
  nhes_in_if.sink                            in_ch,
  nhes_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [nhes_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [nhes_pkg::CFG_W-1:0]         cfg_wdata
);
  import nhes_pkg::*;

  cfg_t cfg_r;
  logic en;
  mat_t in_g;
  logic geo_valid;
  geo_t geo;
  logic res_valid;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mu    <= MU_RST;
      cfg_r.lam   <= LAMBDA_RST;
      cfg_r.alpha <= ALPHA_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MU:     cfg_r.mu    <= cfg_wdata;
        REG_LAMBDA: cfg_r.lam   <= cfg_wdata;
        REG_ALPHA:  cfg_r.alpha <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless a finished result is waiting
  assign en          = !res_valid || out_ch.ready;
  assign in_ch.ready = en;

  assign in_g[0] = in_ch.f00;
  assign in_g[1] = in_ch.f01;
  assign in_g[2] = in_ch.f02;
  assign in_g[3] = in_ch.f10;
  assign in_g[4] = in_ch.f11;
  assign in_g[5] = in_ch.f12;
  assign in_g[6] = in_ch.f20;
  assign in_g[7] = in_ch.f21;
  assign in_g[8] = in_ch.f22;

  nhes_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_g      (in_g),
    .cfg       (cfg_r),
    .geo_valid (geo_valid),
    .geo       (geo)
  );

  nhes_resp u_resp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .geo_valid (geo_valid),
    .geo       (geo),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_ch.valid  = res_valid;
  assign out_ch.energy = res.energy;
  assign out_ch.p00    = res.p[0];
  assign out_ch.p01    = res.p[1];
  assign out_ch.p02    = res.p[2];
  assign out_ch.p10    = res.p[3];
  assign out_ch.p11    = res.p[4];
  assign out_ch.p12    = res.p[5];
  assign out_ch.p20    = res.p[6];
  assign out_ch.p21    = res.p[7];
  assign out_ch.p22    = res.p[8];
endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for neo_hookean_energy_and_stress_top: directed gradients, then
// random ones under several gain settings, with random idling on both channels.
// Depends on nhes_pkg, nhes_in_if, nhes_out_if and the RTL top.
`timescale 1ns / 100ps

module tb_top;
  import nhes_pkg::*;

  localparam int LATENCY      = 13;
  localparam int LIMIT        = 400000;
  localparam int PHASE_ITEMS  = 240;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // past the register list

  typedef logic signed [127:0] acc_t;

  localparam acc_t THREE_Q32 = 128'sd12884901888;

  typedef struct {
    mat_t grad;
    bit   typed;
    res_t want;
  } grad_row_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  nhes_in_if  in_ch ();
  nhes_out_if out_ch ();

  neo_hookean_energy_and_stress_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // gains as the block holds them
  logic [CFG_W-1:0] mu_q, lam_q, alpha_q;

  res_t      due_stress_q[$];
  grad_row_t dir_tab[$];
  int        err_cnt = 0;
  int        cyc_cnt = 0;
  int        tx_calm;
  res_t      seen_res, want_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= LIMIT) begin
      $display("neo_hookean_energy_and_stress_top verification failed");
      $finish;
    end
  end

  function automatic acc_t rshift_round(input acc_t x, input int s);
    acc_t half;
    half = 1;
    half = half <<< (s - 1);
    return (x + half) >>> s;
  endfunction

  function automatic acc_t clamp_bits(input acc_t x, input int bits);
    acc_t top, bot;
    top = 1;
    top = (top <<< (bits - 1)) - 1;
    bot = -top - 1;
    if (x > top) return top;
    if (x < bot) return bot;
    return x;
  endfunction

  // energy and PK1 stress for one gradient under the current gains
  function automatic res_t nh_energy_stress(input mat_t f);
    acc_t g[3][3], cof[3][3], cq[3][3];
    acc_t mu, lam, alpha, ic, jw, d, ld, icm, acc, t;
    int   i, j, a1, a2, b1, b2;
    res_t r;
    mu    = {97'd0, mu_q};
    lam   = {97'd0, lam_q};
    alpha = {97'd0, alpha_q};
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        g[i][j] = signed'(f[i*3+j]);
    ic = 0;
    for (i = 0; i < 3; i++) begin
      a1 = (i + 1) % 3;
      a2 = (i + 2) % 3;
      for (j = 0; j < 3; j++) begin
        b1 = (j + 1) % 3;
        b2 = (j + 2) % 3;
        cof[i][j] = clamp_bits(g[a1][b1] * g[a2][b2] - g[a1][b2] * g[a2][b1], 64);
        cq[i][j]  = clamp_bits(rshift_round(cof[i][j], 16), 64);
        ic = ic + g[i][j] * g[i][j];
      end
    end
    jw = 0;
    for (j = 0; j < 3; j++)
      jw = jw + g[0][j] * cof[0][j];
    jw  = jw - (alpha <<< 32);
    d   = clamp_bits(rshift_round(jw, 32), 48);
    ld  = clamp_bits(rshift_round(lam * d, 16), 64);
    icm = clamp_bits(rshift_round(ic - THREE_Q32, 16), 64);
    acc = mu * icm + ld * d;
    t   = clamp_bits(rshift_round(acc, 17), 32);  // halving folded into the shift
    r.energy = t[31:0];
    for (i = 0; i < 9; i++) begin
      acc = mu * g[i/3][i%3] + ld * cq[i/3][i%3];
      t   = clamp_bits(rshift_round(acc, 16), 32);
      r.p[i] = t[31:0];
    end
    return r;
  endfunction

  function automatic mat_t mk_grad(input word_t a, b, c, d, e, f, g, h, k);
    mat_t m;
    m[0] = a; m[1] = b; m[2] = c;
    m[3] = d; m[4] = e; m[5] = f;
    m[6] = g; m[7] = h; m[8] = k;
    return m;
  endfunction

  function automatic res_t mk_res(input word_t e, input mat_t p);
    res_t r;
    r.energy = e;
    r.p      = p;
    return r;
  endfunction

  function automatic mat_t rand_grad();
    mat_t m;
    int   kind, k, v;
    kind = $urandom_range(0, 9);
    for (k = 0; k < 9; k++) begin
      case (kind)
        0, 1, 2: v = ((k % 4 == 0) ? 65536 : 0) + int'($urandom_range(0, 65536)) - 32768;
        3, 4:    v = int'($urandom_range(0, 1048576)) - 524288;
        7: begin
          case ($urandom_range(0, 5))
            0: v = int'(W_MIN);
            1: v = int'(W_MAX);
            2: v = 0;
            3: v = -1;
            4: v = 65536;
            default: v = $urandom;
          endcase
        end
        9:       v = int'($urandom) >>> $urandom_range(0, 12);
        default: v = $urandom;
      endcase
      m[k] = v;
    end
    // singular: last row repeats the first
    if (kind == 8) m[8:6] = m[2:0];
    return m;
  endfunction

  task automatic send_grad(input mat_t g, input bit typed, input res_t want);
    int gap;
    if (tx_calm > 0) begin
      gap = 0;
      tx_calm--;
    end else begin
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.f00 <= g[0]; in_ch.f01 <= g[1]; in_ch.f02 <= g[2];
    in_ch.f10 <= g[3]; in_ch.f11 <= g[4]; in_ch.f12 <= g[5];
    in_ch.f20 <= g[6]; in_ch.f21 <= g[7]; in_ch.f22 <= g[8];
    do @(posedge clk); while (!in_ch.ready);
    due_stress_q.push_back(typed ? want : nh_energy_stress(g));
  endtask

  task automatic await_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (due_stress_q.size() != 0);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_MU:     mu_q    = val;
      REG_LAMBDA: lam_q   = val;
      REG_ALPHA:  alpha_q = val;
      default: ;
    endcase
  endtask

  task automatic apply_gains(input logic [CFG_W-1:0] mu, lam, alpha, input bit poke_spare);
    set_reg(REG_MU, mu);
    set_reg(REG_LAMBDA, lam);
    set_reg(REG_ALPHA, alpha);
    if (poke_spare) set_reg(REG_SPARE, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls, calm stretches, one long hold-off
  initial begin : result_sink
    int stall;
    int taken;
    int rx_calm;
    bit held;
    out_ch.ready <= 1'b0;
    taken   = 0;
    rx_calm = 0;
    held    = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held && taken == HOLD_AT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (rx_calm > 0) begin
        stall = 0;
        rx_calm--;
      end else begin
        stall = $urandom_range(0, 18);
        if ($urandom_range(0, 29) == 0) rx_calm = $urandom_range(20, 60);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_res.energy = out_ch.energy;
      seen_res.p[0] = out_ch.p00; seen_res.p[1] = out_ch.p01; seen_res.p[2] = out_ch.p02;
      seen_res.p[3] = out_ch.p10; seen_res.p[4] = out_ch.p11; seen_res.p[5] = out_ch.p12;
      seen_res.p[6] = out_ch.p20; seen_res.p[7] = out_ch.p21; seen_res.p[8] = out_ch.p22;
      if (due_stress_q.size() == 0) begin
        $error("result transfer with nothing outstanding: energy %0d",
               $signed(seen_res.energy));
        err_cnt++;
      end else begin
        want_res = due_stress_q.pop_front();
        if (want_res.energy !== seen_res.energy) begin
          $error("energy: expected %0d, actual %0d",
                 $signed(want_res.energy), $signed(seen_res.energy));
          err_cnt++;
        end
        for (int k = 0; k < 9; k++) begin
          if (want_res.p[k] !== seen_res.p[k]) begin
            $error("p%0d%0d: expected %0d, actual %0d", k / 3, k % 3,
                   $signed(want_res.p[k]), $signed(seen_res.p[k]));
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    mat_t             zero_m;
    longint unsigned  ratio;
    logic [CFG_W-1:0] mu_v, lam_v;
    zero_m = '0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= REG_MU;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.f00 <= '0; in_ch.f01 <= '0; in_ch.f02 <= '0;
    in_ch.f10 <= '0; in_ch.f11 <= '0; in_ch.f12 <= '0;
    in_ch.f20 <= '0; in_ch.f21 <= '0; in_ch.f22 <= '0;
    mu_q    = MU_RST;
    lam_q   = LAMBDA_RST;
    alpha_q = ALPHA_RST;
    tx_calm = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains: mu 1.0, lambda 2.0, alpha 1.5
    dir_tab.push_back('{zero_m, 1'b1, mk_res(49152, zero_m)});
    dir_tab.push_back('{mk_grad(65536, 0, 0, 0, 65536, 0, 0, 0, 65536), 1'b1,
                        mk_res(16384, zero_m)});
    dir_tab.push_back('{mk_grad(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX),
                        1'b1, mk_res(W_MAX, mk_grad(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX,
                                                    W_MAX, W_MAX, W_MAX, W_MAX))});
    dir_tab.push_back('{mk_grad(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN),
                        1'b1, mk_res(W_MAX, mk_grad(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN,
                                                    W_MIN, W_MIN, W_MIN, W_MIN))});
    dir_tab.push_back('{mk_grad(W_MAX, 0, 0, 0, W_MAX, 0, 0, 0, W_MAX), 1'b1,
                        mk_res(W_MAX, mk_grad(W_MAX, 0, 0, 0, W_MAX, 0, 0, 0, W_MAX))});
    dir_tab.push_back('{mk_grad(W_MIN, 0, 0, 0, W_MIN, 0, 0, 0, W_MIN), 1'b1,
                        mk_res(W_MAX, mk_grad(W_MIN, 0, 0, 0, W_MIN, 0, 0, 0, W_MIN))});
    dir_tab.push_back('{mk_grad(-65536, 0, 0, 0, -65536, 0, 0, 0, -65536), 1'b1,
                        mk_res(409600, mk_grad(-393216, 0, 0, 0, -393216, 0, 0, 0, -393216))});
    dir_tab.push_back('{mk_grad(131072, 0, 0, 0, 131072, 0, 0, 0, 131072), 1'b1,
                        mk_res(3063808, mk_grad(3538944, 0, 0, 0, 3538944, 0, 0, 0, 3538944))});
    dir_tab.push_back('{mk_grad(W_MAX, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_tab.push_back('{mk_grad(0, 0, 0, 0, 0, 0, 0, 0, W_MIN), 1'b0, '0});
    dir_tab.push_back('{mk_grad(-1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b0, '0});
    dir_tab.push_back('{mk_grad(1, 1, 1, 1, 1, 1, 1, 1, 1), 1'b0, '0});
    dir_tab.push_back('{mk_grad(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555,
                                32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA,
                                32'sh55555555, 32'shAAAAAAAA, 32'sh55555555), 1'b0, '0});
    dir_tab.push_back('{mk_grad(0, -65536, 0, 65536, 0, 0, 0, 0, 65536), 1'b0, '0});
    dir_tab.push_back('{mk_grad(65536, 32768, 0, 0, 65536, 0, 0, 0, 65536), 1'b0, '0});
    dir_tab.push_back('{mk_grad(32768, 1, -1, 1, 32768, 1, -1, 1, 32768), 1'b0, '0});
    dir_tab.push_back('{mk_grad(W_MAX, W_MIN, 0, W_MIN, W_MAX, 1, 0, -1, W_MAX), 1'b0, '0});
    dir_tab.push_back('{mk_grad(65536, 131072, -196608, 65536, 131072, -196608,
                                65536, 131072, -196608), 1'b0, '0});
    dir_tab.push_back('{mk_grad(65536, 0, 0, 0, 65536, 0, 0, 0, -65536), 1'b0, '0});
    dir_tab.push_back('{mk_grad(32'sh01000000, 0, 0, 0, 32'sh01000000, 0, 0, 0,
                                32'sh01000000), 1'b0, '0});
    foreach (dir_tab[n])
      send_grad(dir_tab[n].grad, dir_tab[n].typed, dir_tab[n].want);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        await_drain();
        case (ph)
          1: apply_gains(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0);
          2: apply_gains('0, '0, '0, 1'b1);
          3: begin
            mu_v  = $urandom_range(6554, 655360);
            lam_v = mu_v + CFG_W'($urandom_range(6554, 1310720));
            ratio = ({33'd0, mu_v} << 16) / lam_v;
            apply_gains(mu_v, lam_v, CFG_W'(65536 + ratio), 1'b0);
          end
          4: apply_gains(31'd1, 31'd1, 31'h7FFFFFFF, 1'b0);
          default: apply_gains(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), 1'b1);
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // back-to-back offers while the result side holds off
        if (ph == 0 && n == 130) tx_calm = 70;
        send_grad(rand_grad(), 1'b0, '0);
      end
    end

    await_drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("neo_hookean_energy_and_stress_top verification clean");
    end else begin
      $display("neo_hookean_energy_and_stress_top verification failed");
    end
    $finish;
  end

endmodule
